[sv/sset_pkg.sv]
// Package for the sampled sieve eviction table: sizes, register indexes,
// table entry layout, controller/datapath command and status types.
// No dependencies.
`default_nettype none
package sset_pkg;

	localparam int TABLE_SLOTS_DEF = 1024;
	localparam int MAX_SAMPLES_DEF = 16;

	localparam int CFG_W     = 32;
	localparam int CFG_IDX_W = 2;
	localparam int ID_W      = 32;
	localparam int TIME_W    = 32;
	localparam int NAT_W     = 33;
	localparam int K_REG_W   = 5;
	localparam int CAP_REG_W = 11;

	localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_COUNT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLAY_END   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RANDOM_SEED  = 2'd3;

	localparam logic [K_REG_W-1:0]   SAMPLE_RST   = 5'd5;
	localparam logic [CAP_REG_W-1:0] CAPACITY_RST = 11'd1024;
	localparam logic [TIME_W-1:0]    REPLAY_RST   = '1;
	localparam logic [31:0]          SEED_RST     = 32'd1;
	localparam logic [31:0]          LFSR_MASK    = 32'h8020_0003;

	// one table entry as stored in the slot memory
	typedef struct packed {
		logic              valid;
		logic              ref_bit;
		logic [TIME_W-1:0] last;
		logic [ID_W-1:0]   obj;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// controller to datapath, one action per cycle
	typedef struct packed {
		logic clear_wr;
		logic load;
		logic scan_rd;
		logic draw;
		logic mod_step;
		logic probe_take;
		logic probe_next;
		logic wr_hit;
		logic wr_remove;
		logic evict;
		logic insert;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic addr_last;
		logic is_remove;
		logic found;
		logic admissible;
		logic at_cap;
		logic below_cap;
		logic mod_last;
		logic probe_ok;
		logic draw_last;
	} dp_sts_t;

	// Galois LFSR step
	function automatic logic [31:0] lfsr_next(input logic [31:0] x);
		logic [31:0] y;
		y = x >> 1;
		if (x[0]) begin
			y = y ^ LFSR_MASK;
		end
		return y;
	endfunction

endpackage
`default_nettype wire

[sv/sset_ram.sv]
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none
module sset_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule
`default_nettype wire

[sv/sset_ctrl.sv]
// Controller state machine of the eviction table: clearing pass, scan, hit and
// remove writes, random draw with probing, eviction and insertion. Uses sset_pkg.
`default_nettype none
module sset_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	output logic                   done,
	output sset_pkg::dp_cmd_t      cmd_o,
	input  wire sset_pkg::dp_sts_t sts
);
	import sset_pkg::*;

	localparam logic [3:0] S_CLR      = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_SCAN     = 4'd2;
	localparam logic [3:0] S_SCAN_END = 4'd3;
	localparam logic [3:0] S_DECIDE   = 4'd4;
	localparam logic [3:0] S_DRAW     = 4'd5;
	localparam logic [3:0] S_MOD      = 4'd6;
	localparam logic [3:0] S_PRB_RD   = 4'd7;
	localparam logic [3:0] S_PRB_CHK  = 4'd8;
	localparam logic [3:0] S_EVICT    = 4'd9;
	localparam logic [3:0] S_INSERT   = 4'd10;
	localparam logic [3:0] S_DONE     = 4'd11;

	logic [3:0] state_q, state_d;

	// next state and commands
	always_comb begin
		state_d = state_q;
		cmd_o   = '0;
		unique case (state_q)
			S_CLR: begin
				cmd_o.clear_wr = 1'b1;
				if (sts.addr_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					cmd_o.load = 1'b1;
					state_d    = S_SCAN;
				end
			end
			S_SCAN: begin
				cmd_o.scan_rd = 1'b1;
				if (sts.addr_last) state_d = S_SCAN_END;
			end
			S_SCAN_END: state_d = S_DECIDE;
			S_DECIDE: begin
				state_d = S_DONE;
				if (sts.is_remove) begin
					cmd_o.wr_remove = sts.found;
				end else if (sts.found) begin
					cmd_o.wr_hit = 1'b1;
				end else if (sts.admissible) begin
					state_d = sts.at_cap ? S_DRAW : S_INSERT;
				end
			end
			S_DRAW: begin
				cmd_o.draw = 1'b1;
				state_d    = S_MOD;
			end
			S_MOD: begin
				cmd_o.mod_step = 1'b1;
				if (sts.mod_last) state_d = S_PRB_RD;
			end
			S_PRB_RD: state_d = S_PRB_CHK;
			S_PRB_CHK: begin
				if (sts.probe_ok) begin
					cmd_o.probe_take = 1'b1;
					state_d = sts.draw_last ? S_EVICT : S_DRAW;
				end else begin
					cmd_o.probe_next = 1'b1;
					state_d = S_PRB_RD;
				end
			end
			S_EVICT: begin
				cmd_o.evict = 1'b1;
				state_d     = S_INSERT;
			end
			S_INSERT: begin
				cmd_o.insert = sts.below_cap;
				state_d      = S_DONE;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
		end else begin
			state_q <= state_d;
		end
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);

endmodule
`default_nettype wire

[sv/sset_dp.sv]
// Datapath of the eviction table: configuration registers, slot memory,
// scan, LFSR draw with modulo reduction, candidate compare, counters.
// Uses sset_pkg and sset_ram.
`default_nettype none
module sset_dp #(
	parameter int TABLE_SLOTS = sset_pkg::TABLE_SLOTS_DEF,
	parameter int MAX_SAMPLES = sset_pkg::MAX_SAMPLES_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire sset_pkg::dp_cmd_t             cmd_i,
	output sset_pkg::dp_sts_t                  sts,
	input  wire logic                          cfg_we,
	input  wire logic [sset_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire logic [sset_pkg::CFG_W-1:0]    cfg_wdata,
	input  wire logic                          in_cmd,
	input  wire logic [sset_pkg::ID_W-1:0]     in_obj,
	input  wire logic signed [sset_pkg::NAT_W-1:0] in_nat,
	output logic                               hit,
	output logic                               admitted,
	output logic                               evicted,
	output logic [sset_pkg::ID_W-1:0]          victim_id,
	output logic                               removed
);
	import sset_pkg::*;

	localparam int IW     = $clog2(TABLE_SLOTS);
	localparam int CNT_W  = $clog2(TABLE_SLOTS + 1);
	localparam int CAP_W  = (CNT_W > CAP_REG_W) ? CNT_W : CAP_REG_W;
	localparam int SW     = $clog2(MAX_SAMPLES + 1);
	localparam int KW     = (SW > K_REG_W) ? SW : K_REG_W;
	localparam int RSH    = 32 + IW;
	localparam logic [IW-1:0]    LAST_SLOT = IW'(TABLE_SLOTS - 1);
	localparam logic [CAP_W-1:0] CAP_MAX   = CAP_W'(TABLE_SLOTS);
	localparam logic [KW-1:0]    K_MAX     = KW'(MAX_SAMPLES);
	localparam logic [31:0]      MOD_DIV   = 32'(TABLE_SLOTS);
	localparam logic [32:0]      RECIP     = 33'((64'd1 << RSH) / 64'(TABLE_SLOTS));
	localparam logic [5:0]       MOD_STEPS = 6'd2;

	// configuration
	logic [K_REG_W-1:0]   sample_q;
	logic [CAP_REG_W-1:0] cap_q;
	logic [TIME_W-1:0]    replay_q;
	logic [31:0]          lfsr_q;

	// request state
	logic              cmd_q;
	logic [ID_W-1:0]   obj_q;
	logic              adm_q;
	logic [TIME_W-1:0] req_cnt_q;
	logic [CNT_W-1:0]  occ_q;
	logic [IW-1:0]     addr_q;
	logic              scan_s1;
	logic [IW-1:0]     scan_addr_s1;
	logic              found_q;
	logic [IW-1:0]     found_slot_q;
	logic              free_q;
	logic [IW-1:0]     free_slot_q;

	// draw state
	logic [31:0]       mod_q;
	logic [31:0]       quo_q;
	logic [5:0]        sh_q;
	logic [IW-1:0]     probe_q;
	logic [SW-1:0]     draw_cnt_q;
	logic [SW-1:0]     n_tgt_q;
	logic [IW-1:0]     cand_q [MAX_SAMPLES];
	logic [IW-1:0]     best_slot_q;
	entry_t            best_q;

	// memory ports
	logic              ram_we;
	logic [IW-1:0]     ram_waddr;
	entry_t            ram_wdata;
	logic [IW-1:0]     ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;
	entry_t            rd;

	assign rd = entry_t'(ram_rdata);

	sset_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(TABLE_SLOTS)
	) u_slots (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// effective capacity and sample count
	logic [CAP_W-1:0] cap_x, cap_eff;
	logic [KW-1:0]    k_x, k_eff;
	always_comb begin
		cap_x   = CAP_W'(cap_q);
		cap_eff = cap_x;
		if (cap_x == '0) cap_eff = CAP_W'(1);
		else if (cap_x > CAP_MAX) cap_eff = CAP_MAX;
		k_x   = KW'(sample_q);
		k_eff = k_x;
		if (k_x == '0) k_eff = KW'(1);
		else if (k_x > K_MAX) k_eff = K_MAX;
	end

	// already drawn check for the probed slot
	logic drawn;
	always_comb begin
		drawn = 1'b0;
		for (int j = 0; j < MAX_SAMPLES; j++) begin
			if ((SW'(j) < draw_cnt_q) && (cand_q[j] == probe_q)) drawn = 1'b1;
		end
	end

	// candidate beats current best: clear ref bit first, then older time
	logic better;
	assign better = (!rd.ref_bit && best_q.ref_bit) ||
		((rd.ref_bit == best_q.ref_bit) && (rd.last < best_q.last));

	// modulo reduction: reciprocal quotient estimate (low by at most one),
	// back-multiply and subtract, then one conditional correction
	logic [64:0]   quo_prod;
	logic [31:0]   quo_est;
	logic [31:0]   rem_raw;
	logic [IW-1:0] rem_fin;
	always_comb begin
		quo_prod = 65'(mod_q) * 65'(RECIP);
		quo_est  = 32'(quo_prod >> RSH);
		rem_raw  = mod_q - 32'(quo_q * MOD_DIV);
		rem_fin  = (mod_q >= MOD_DIV) ? IW'(mod_q - MOD_DIV) : mod_q[IW-1:0];
	end

	// status
	always_comb begin
		sts.addr_last  = (addr_q == LAST_SLOT);
		sts.is_remove  = cmd_q;
		sts.found      = found_q;
		sts.admissible = adm_q;
		sts.at_cap     = (CAP_W'(occ_q) >= cap_eff);
		sts.below_cap  = (CAP_W'(occ_q) < cap_eff);
		sts.mod_last   = (sh_q == '0);
		sts.probe_ok   = rd.valid && !drawn;
		sts.draw_last  = (draw_cnt_q == n_tgt_q - SW'(1));
	end

	// memory write and read selection
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = addr_q;
		ram_wdata = '0;
		ram_raddr = cmd_i.scan_rd ? addr_q : probe_q;
		if (cmd_i.clear_wr) begin
			ram_we = 1'b1;
		end else if (cmd_i.wr_remove) begin
			ram_we    = 1'b1;
			ram_waddr = found_slot_q;
		end else if (cmd_i.wr_hit) begin
			ram_we    = 1'b1;
			ram_waddr = found_slot_q;
			ram_wdata = '{valid: 1'b1, ref_bit: 1'b1, last: req_cnt_q, obj: obj_q};
		end else if (cmd_i.evict) begin
			ram_we    = 1'b1;
			ram_waddr = best_slot_q;
		end else if (cmd_i.insert) begin
			ram_we    = 1'b1;
			ram_waddr = free_slot_q;
			ram_wdata = '{valid: 1'b1, ref_bit: 1'b0, last: req_cnt_q, obj: obj_q};
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sample_q   <= SAMPLE_RST;
			cap_q      <= CAPACITY_RST;
			replay_q   <= REPLAY_RST;
			lfsr_q     <= SEED_RST;
			req_cnt_q  <= '0;
			occ_q      <= '0;
			addr_q     <= '0;
			scan_s1    <= 1'b0;
			found_q    <= 1'b0;
			free_q     <= 1'b0;
			draw_cnt_q <= '0;
			n_tgt_q    <= '0;
			sh_q       <= '0;
			cmd_q      <= 1'b0;
			adm_q      <= 1'b0;
			hit        <= 1'b0;
			admitted   <= 1'b0;
			evicted    <= 1'b0;
			removed    <= 1'b0;
			victim_id  <= '0;
		end else begin
			// configuration writes
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SAMPLE_COUNT: sample_q <= cfg_wdata[K_REG_W-1:0];
					REG_CAPACITY:     cap_q    <= cfg_wdata[CAP_REG_W-1:0];
					REG_REPLAY_END:   replay_q <= cfg_wdata[TIME_W-1:0];
					REG_RANDOM_SEED:  lfsr_q   <= (cfg_wdata == '0) ? 32'd1 : cfg_wdata;
					default: ;
				endcase
			end
			// clearing pass and scan address
			if (cmd_i.clear_wr || cmd_i.scan_rd) begin
				addr_q <= (addr_q == LAST_SLOT) ? '0 : addr_q + IW'(1);
			end
			scan_s1 <= cmd_i.scan_rd;
			// new request
			if (cmd_i.load) begin
				cmd_q      <= in_cmd;
				adm_q      <= !in_nat[NAT_W-1] && (in_nat[TIME_W-1:0] <= replay_q);
				addr_q     <= '0;
				found_q    <= 1'b0;
				free_q     <= 1'b0;
				draw_cnt_q <= '0;
				n_tgt_q    <= (32'(k_eff) < 32'(occ_q)) ? SW'(k_eff) : SW'(occ_q);
				if (!in_cmd) req_cnt_q <= req_cnt_q + 32'd1;
				hit       <= 1'b0;
				admitted  <= 1'b0;
				evicted   <= 1'b0;
				removed   <= 1'b0;
				victim_id <= '0;
			end
			// scan result of the slot read last cycle
			if (scan_s1) begin
				if (rd.valid && (rd.obj == obj_q) && !found_q) begin
					found_q <= 1'b1;
				end
				if (!rd.valid && !free_q) begin
					free_q <= 1'b1;
				end
			end
			// draw: step LFSR, start reduction
			if (cmd_i.draw) begin
				lfsr_q <= lfsr_next(lfsr_q);
				sh_q   <= MOD_STEPS;
			end else if (cmd_i.mod_step) begin
				sh_q <= sh_q - 6'd1;
			end
			if (cmd_i.probe_take) begin
				draw_cnt_q <= draw_cnt_q + SW'(1);
			end
			if (cmd_i.wr_remove) begin
				occ_q   <= occ_q - CNT_W'(1);
				removed <= 1'b1;
			end
			if (cmd_i.wr_hit) begin
				hit <= 1'b1;
			end
			if (cmd_i.evict) begin
				occ_q     <= occ_q - CNT_W'(1);
				evicted   <= 1'b1;
				victim_id <= best_q.obj;
			end
			if (cmd_i.insert) begin
				occ_q    <= occ_q + CNT_W'(1);
				admitted <= 1'b1;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_i.load) begin
			obj_q <= in_obj;
		end
		if (scan_s1) begin
			scan_addr_s1 <= addr_q;
		end else if (cmd_i.scan_rd) begin
			scan_addr_s1 <= addr_q;
		end
		if (scan_s1 && rd.valid && (rd.obj == obj_q) && !found_q) begin
			found_slot_q <= scan_addr_s1;
		end
		if (scan_s1 && !rd.valid && !free_q) begin
			free_slot_q <= scan_addr_s1;
		end
		if (cmd_i.draw) begin
			mod_q <= lfsr_next(lfsr_q);
		end else if (cmd_i.mod_step) begin
			if (sh_q == MOD_STEPS) quo_q <= quo_est;
			if (sh_q == 6'd1) mod_q <= rem_raw;
			if (sh_q == '0) probe_q <= rem_fin;
		end else if (cmd_i.probe_next) begin
			probe_q <= (probe_q == LAST_SLOT) ? '0 : probe_q + IW'(1);
		end
		if (cmd_i.probe_take) begin
			for (int j = 0; j < MAX_SAMPLES; j++) begin
				if (SW'(j) == draw_cnt_q) cand_q[j] <= probe_q;
			end
			if ((draw_cnt_q == '0) || better) begin
				best_q      <= rd;
				best_slot_q <= probe_q;
			end
		end
		// victim slot becomes the insertion slot if no free slot was found or it comes first
		if (cmd_i.evict && (!free_q || (best_slot_q < free_slot_q))) begin
			free_slot_q <= best_slot_q;
		end
	end

endmodule
`default_nettype wire

[sv/sampled_sieve_eviction_table_core.sv]
// Top level of the sampled sieve eviction table: controller and datapath.
// Uses sset_pkg, sset_ctrl and sset_dp.
//
//  channel   ports                                     handshake
//  request   cmd, obj_id, next_access_time             start, busy
//  result    hit, admitted, evicted, victim_id, removed done strobe, one cycle
//  config    cfg_we, cfg_index, cfg_wdata              cfg_we
//
// After reset a clearing pass over every slot runs with busy high.
// A request holds busy through the scan, the decision and any insertion:
// the slot memory is scanned one entry a cycle through its single read port.
// An eviction adds, per drawn slot, an LFSR step and the modulo reduction
// plus a read and check per probed slot, then the eviction write.
// The result is shown for one cycle on done; the receiver cannot stall.
`default_nettype none
module sampled_sieve_eviction_table_core #(
	parameter int TABLE_SLOTS = sset_pkg::TABLE_SLOTS_DEF,
	parameter int MAX_SAMPLES = sset_pkg::MAX_SAMPLES_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              start,
	output logic                                   busy,
	input  wire logic                              cmd,
	input  wire logic [sset_pkg::ID_W-1:0]         obj_id,
	input  wire logic signed [sset_pkg::NAT_W-1:0] next_access_time,
	input  wire logic                              cfg_we,
	input  wire logic [sset_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [sset_pkg::CFG_W-1:0]        cfg_wdata,
	output logic                                   done,
	output logic                                   hit,
	output logic                                   admitted,
	output logic                                   evicted,
	output logic [sset_pkg::ID_W-1:0]              victim_id,
	output logic                                   removed
);
	import sset_pkg::*;

	dp_cmd_t dp_cmd;
	dp_sts_t dp_sts;

	sset_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.cmd_o (dp_cmd),
		.sts   (dp_sts)
	);

	sset_dp #(
		.TABLE_SLOTS(TABLE_SLOTS),
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_i    (dp_cmd),
		.sts      (dp_sts),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.in_cmd   (cmd),
		.in_obj   (obj_id),
		.in_nat   (next_access_time),
		.hit      (hit),
		.admitted (admitted),
		.evicted  (evicted),
		.victim_id(victim_id),
		.removed  (removed)
	);

	// result strobe is a single cycle
	assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done held for more than one cycle");
	// a hit neither admits nor evicts nor removes
	assert property (@(posedge clk) disable iff (!arst_n)
		done && hit |-> !admitted && !evicted && !removed)
		else $error("hit with other outcome");
	// a remove reports no access outcome
	assert property (@(posedge clk) disable iff (!arst_n)
		done && removed |-> !hit && !admitted && !evicted)
		else $error("remove with access outcome");
	// an accepted request makes the block busy
	assert property (@(posedge clk) disable iff (!arst_n) start && !busy |=> busy)
		else $error("request accepted without going busy");
	// no victim id without an eviction
	assert property (@(posedge clk) disable iff (!arst_n)
		done && !evicted |-> victim_id == '0)
		else $error("victim id without eviction");

endmodule
`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench for sampled_sieve_eviction_table_core.
// Depends on sset_pkg and the core RTL; a behavioral model of the table
// predicts every result and a monitor compares each done strobe against it.
`timescale 1ns / 1ps
module testbench;
	import sset_pkg::*;

	localparam int SLOTS   = TABLE_SLOTS_DEF;
	localparam int SAMPLES = MAX_SAMPLES_DEF;
	localparam int STALL_LIMIT = 200000;
	localparam logic CMD_ACCESS = 1'b0;
	localparam logic CMD_REMOVE = 1'b1;

	typedef enum logic [1:0] {OP_REQUEST, OP_CFG_WRITE, OP_DRAIN} op_kind_t;

	typedef struct {
		op_kind_t              kind;
		logic                  cmd;
		logic [ID_W-1:0]       id;
		logic [NAT_W-1:0]      nat;
		logic [CFG_IDX_W-1:0]  idx;
		logic [CFG_W-1:0]      data;
	} op_t;

	typedef struct {
		logic            hit;
		logic            admitted;
		logic            evicted;
		logic [ID_W-1:0] victim;
		logic            removed;
	} outcome_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic cmd = 1'b0;
	logic [ID_W-1:0] obj_id = '0;
	logic signed [NAT_W-1:0] next_access_time = '0;
	logic cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_wdata = '0;
	logic busy, done, hit, admitted, evicted, removed;
	logic [ID_W-1:0] victim_id;

	op_t      pending_ops[$];
	outcome_t expected_outcomes[$];
	int       errors = 0;
	int       idle_cycles = 0;
	int       gap_left = 0;
	logic [ID_W-1:0] id_pool[48];

	// table mirror
	bit                m_valid[SLOTS];
	logic [ID_W-1:0]   m_obj[SLOTS];
	bit                m_ref[SLOTS];
	logic [TIME_W-1:0] m_last[SLOTS];
	int unsigned       m_occ;
	logic [31:0]       m_req_count;
	logic [31:0]       m_lfsr;
	logic [K_REG_W-1:0]   m_k;
	logic [CAP_REG_W-1:0] m_cap;
	logic [TIME_W-1:0]    m_replay_end;
	int unsigned       m_cand[SAMPLES];

	sampled_sieve_eviction_table_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.obj_id(obj_id), .next_access_time(next_access_time), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_wdata(cfg_wdata), .done(done), .hit(hit),
		.admitted(admitted), .evicted(evicted), .victim_id(victim_id), .removed(removed)
	);

	always #5 clk = ~clk;

	function automatic int find_slot(logic [ID_W-1:0] id);
		for (int i = 0; i < SLOTS; i++)
			if (m_valid[i] && m_obj[i] == id) return i;
		return -1;
	endfunction

	function automatic void mirror_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
		case (idx)
			REG_SAMPLE_COUNT: m_k = d[K_REG_W-1:0];
			REG_CAPACITY:     m_cap = d[CAP_REG_W-1:0];
			REG_REPLAY_END:   m_replay_end = d;
			REG_RANDOM_SEED:  m_lfsr = (d == 0) ? 32'd1 : d;
			default: ;
		endcase
	endfunction

	// sampled victim choice: clear reference bit first, then older stamp
	function automatic int pick_victim();
		int unsigned k, n, s, best, c;
		bit seen;
		k = m_k;
		if (k < 1) k = 1;
		if (k > SAMPLES) k = SAMPLES;
		n = (k < m_occ) ? k : m_occ;
		for (int i = 0; i < n; i++) begin
			m_lfsr = (m_lfsr >> 1) ^ (m_lfsr[0] ? LFSR_MASK : 32'd0);
			s = m_lfsr % SLOTS;
			for (int p = 0; p < SLOTS; p++) begin
				seen = 0;
				for (int j = 0; j < i; j++)
					if (m_cand[j] == s) seen = 1;
				if (m_valid[s] && !seen) break;
				s = (s + 1) % SLOTS;
			end
			m_cand[i] = s;
		end
		best = m_cand[0];
		for (int i = 1; i < n; i++) begin
			c = m_cand[i];
			if ((!m_ref[c] && m_ref[best]) ||
			    (m_ref[c] == m_ref[best] && m_last[c] < m_last[best]))
				best = c;
		end
		return best;
	endfunction

	function automatic outcome_t table_step(logic c, logic [ID_W-1:0] id, logic [NAT_W-1:0] nat);
		outcome_t r;
		int slot, v, cap;
		r = '{default: '0};
		slot = find_slot(id);
		if (c == CMD_REMOVE) begin
			if (slot >= 0) begin
				m_valid[slot] = 0;
				m_occ--;
				r.removed = 1;
			end
		end else begin
			m_req_count++;
			if (slot >= 0) begin
				r.hit = 1;
				m_ref[slot] = 1;
				m_last[slot] = m_req_count;
			end else if (!nat[32] && nat[31:0] <= m_replay_end) begin
				cap = m_cap;
				if (cap < 1) cap = 1;
				if (cap > SLOTS) cap = SLOTS;
				if (m_occ >= cap) begin
					v = pick_victim();
					r.victim = m_obj[v];
					m_valid[v] = 0;
					m_occ--;
					r.evicted = 1;
				end
				if (m_occ < cap) begin
					for (int i = 0; i < SLOTS; i++)
						if (!m_valid[i]) begin
							m_valid[i] = 1;
							m_obj[i] = id;
							m_ref[i] = 0;
							m_last[i] = m_req_count;
							m_occ++;
							r.admitted = 1;
							break;
						end
				end
			end
		end
		return r;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 65) return 0;
		if (r < 95) return $urandom_range(1, 4);
		return $urandom_range(20, 300);
	endfunction

	// driver: one transfer, config write or drain step per edge, held back by busy, random gaps and pending results
	always @(posedge clk) begin
		logic go, we;
		op_t o;
		go = start;
		we = 1'b0;
		if (arst_n) begin
			if (start && !busy) begin
				expected_outcomes.push_back(table_step(cmd, obj_id, next_access_time));
				go = 1'b0;
			end
			if (!go) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending_ops.size() > 0) begin
					o = pending_ops[0];
					case (o.kind)
						OP_REQUEST: begin
							void'(pending_ops.pop_front());
							cmd <= o.cmd;
							obj_id <= o.id;
							next_access_time <= o.nat;
							go = 1'b1;
							gap_left = pick_gap();
						end
						OP_CFG_WRITE: begin
							if (expected_outcomes.size() == 0 && !busy) begin
								void'(pending_ops.pop_front());
								we = 1'b1;
								cfg_index <= o.idx;
								cfg_wdata <= o.data;
								mirror_cfg(o.idx, o.data);
							end
						end
						default: begin
							if (expected_outcomes.size() == 0) void'(pending_ops.pop_front());
						end
					endcase
				end
			end
		end
		start <= go;
		cfg_we <= we;
	end

	// monitor: compare each result strobe against the oldest prediction
	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && done) begin
			if (expected_outcomes.size() == 0) begin
				$error("unexpected result transfer");
				errors++;
			end else begin
				e = expected_outcomes.pop_front();
				if (hit !== e.hit) begin
					$error("hit expected %0d actual %0d", e.hit, hit); errors++;
				end
				if (admitted !== e.admitted) begin
					$error("admitted expected %0d actual %0d", e.admitted, admitted); errors++;
				end
				if (evicted !== e.evicted) begin
					$error("evicted expected %0d actual %0d", e.evicted, evicted); errors++;
				end
				if (victim_id !== e.victim) begin
					$error("victim_id expected %h actual %h", e.victim, victim_id); errors++;
				end
				if (removed !== e.removed) begin
					$error("removed expected %0d actual %0d", e.removed, removed); errors++;
				end
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if ((start && !busy) || done) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic add_request(logic c, logic [ID_W-1:0] id, logic [NAT_W-1:0] nat);
		op_t o;
		o = '{kind: OP_REQUEST, cmd: c, id: id, nat: nat, idx: '0, data: '0};
		pending_ops.push_back(o);
	endtask

	task automatic add_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
		op_t o;
		o = '{kind: OP_CFG_WRITE, cmd: 1'b0, id: '0, nat: '0, idx: idx, data: d};
		pending_ops.push_back(o);
	endtask

	task automatic add_drain();
		op_t o;
		o = '{kind: OP_DRAIN, cmd: 1'b0, id: '0, nat: '0, idx: '0, data: '0};
		pending_ops.push_back(o);
	endtask

	task automatic add_phase(logic [CFG_W-1:0] k, logic [CFG_W-1:0] cap,
	                         logic [CFG_W-1:0] rend, logic [CFG_W-1:0] seed);
		add_drain();
		add_cfg(REG_SAMPLE_COUNT, k);
		add_cfg(REG_CAPACITY, cap);
		add_cfg(REG_REPLAY_END, rend);
		add_cfg(REG_RANDOM_SEED, seed);
	endtask

	// random mix: mostly accesses to a small id pool, some removes and noise
	task automatic add_burst(int n, int pool);
		logic [ID_W-1:0] id;
		logic [NAT_W-1:0] nat;
		int r;
		for (int i = 0; i < n; i++) begin
			r = $urandom_range(99);
			id = (r < 8) ? $urandom() : id_pool[$urandom_range(pool - 1)];
			r = $urandom_range(99);
			if (r < 75) nat = {1'b0, 32'($urandom_range(2000))};
			else if (r < 85) nat = {1'b1, 32'($urandom())};
			else nat = {1'b0, 32'($urandom())};
			add_request(($urandom_range(99) < 15) ? CMD_REMOVE : CMD_ACCESS, id, nat);
		end
	endtask

	initial begin
		m_valid = '{default: 0};
		m_occ = 0;
		m_req_count = 0;
		m_lfsr = SEED_RST;
		m_k = SAMPLE_RST;
		m_cap = CAPACITY_RST;
		m_replay_end = REPLAY_RST;
		for (int i = 0; i < 48; i++) id_pool[i] = $urandom();
		id_pool[0] = '0;
		id_pool[1] = '1;

		// directed: field extremes, hit, never-accessed bypass, removes
		add_request(CMD_ACCESS, 32'h0, 33'h0);
		add_request(CMD_ACCESS, 32'hFFFF_FFFF, {1'b0, 32'hFFFF_FFFF});
		add_request(CMD_ACCESS, 32'h1234_5678, '1);
		add_request(CMD_ACCESS, 32'h0, 33'h5);
		add_request(CMD_REMOVE, 32'hFFFF_FFFF, '0);
		add_request(CMD_REMOVE, 32'hFFFF_FFFF, '0);
		add_request(CMD_ACCESS, 32'h1234_5678, 33'h7);
		// single slot, single sample, replay end at zero
		add_phase(32'hFFFF_FFE1, 32'hFFFF_F801, 32'h0, 32'h0);
		add_request(CMD_ACCESS, 32'hA, 33'h0);
		add_request(CMD_ACCESS, 32'hB, 33'h1);
		add_request(CMD_ACCESS, 32'hB, 33'h0);
		add_request(CMD_ACCESS, 32'hA, 33'h0);
		// zero sample count and capacity, largest replay end
		add_phase(32'h0, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		add_request(CMD_ACCESS, 32'hC, 33'h9);
		add_request(CMD_ACCESS, 32'hD, {1'b0, 32'hFFFF_FFFF});
		add_burst(20, 6);
		// sixteen samples, capacity sixteen
		add_phase(32'd16, 32'd16, 32'd1500, 32'hDEAD_BEEF);
		add_burst(120, 40);
		add_drain();
		// capacity lowered below occupancy
		add_phase(32'd5, 32'd4, 32'd1500, 32'h1357_9BDF);
		add_burst(60, 12);
		// oversized sample count and capacity
		add_phase(32'd31, 32'h7FF, 32'd2000, 32'h8000_0000);
		add_burst(30, 48);
		add_phase(32'd3, 32'd8, 32'd1000, 32'h0000_0001);
		add_burst(120, 20);
		add_phase(32'd7, 32'd2, 32'hFFFF_FFFF, 32'h5A5A_A5A5);
		add_burst(80, 10);
		add_drain();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		wait (pending_ops.size() == 0);
		@(posedge clk);
		while (start || busy || expected_outcomes.size() != 0) @(posedge clk);
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_outcomes.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end
endmodule
